[rtl/core/frustum_box_cull_assert.svh]
// Assertion macros shared by the frustum box cull checkers.
`ifndef FRUSTUM_BOX_CULL_ASSERT_SVH
`define FRUSTUM_BOX_CULL_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define FBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define FBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/fbc_pkg.sv]
// Shared types and constants for the frustum box cull block.
`default_nettype none

package fbc_pkg;

  // Width of every coordinate and matrix field on the ports.
  localparam int FIELD_W = 32;

  // Item operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // Load enables for the plane pipeline stages.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } fbc_en_t;

endpackage

`default_nettype wire

[rtl/core/frustum_box_cull.sv]
// Frustum box cull: top level with matrix store, plane forming and pipeline control.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer. op = load
//   writes matrix row `row` from m0..m3 and gives no result. op = test carries
//   a box minimum corner (pos_*) and extent (size_*) and gives one result.
//   Output channel (out_valid/out_ready) carries visible: 1 when the box lies
//   on the inner side of all six frustum planes, 0 when it is culled.
//   Throughput: one item per cycle while the receiver does not stall. Each test
//   result passes through a capture stage, vertex, multiply, partial sum, and
//   the final add registered into the output.
//   A test sees every load transferred before it.
//   Reset clears the matrix to zero and empties the pipeline.
//   When the receiver stalls, each stage holds its item; bubbles still close up,
//   so in_ready drops only once all five stages hold tests.
//   Results come out in the order the tests went in.
`default_nettype none

module frustum_box_cull import fbc_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [1:0]         row,
  input  wire logic [FIELD_W-1:0] m0,
  input  wire logic [FIELD_W-1:0] m1,
  input  wire logic [FIELD_W-1:0] m2,
  input  wire logic [FIELD_W-1:0] m3,
  input  wire logic [FIELD_W-1:0] pos_x,
  input  wire logic [FIELD_W-1:0] pos_y,
  input  wire logic [FIELD_W-1:0] pos_z,
  input  wire logic [FIELD_W-1:0] size_x,
  input  wire logic [FIELD_W-1:0] size_y,
  input  wire logic [FIELD_W-1:0] size_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    visible
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = CW + 1;

  logic signed [CW-1:0] mat [16];
  logic signed [CW-1:0] mrow [4];
  logic signed [NW-1:0] n_next [6][3];
  logic signed [NW-1:0] d_next [6];
  logic signed [NW-1:0] n1 [6][3];
  logic signed [NW-1:0] d1 [6];
  logic signed [CW-1:0] pos1 [3];
  logic signed [CW-1:0] size1 [3];
  logic [5:0]           culled;
  logic                 v1, v2, v3, v4;
  logic                 en1, en2, en3, en4, en5;
  logic                 in_xfer;
  fbc_en_t              pen;

  // Stage enables: a stage takes new data when empty or when it drains
  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign in_xfer  = in_valid && in_ready;
  assign pen      = '{s2: en2, s3: en3, s4: en4};

  // Matrix row from the input fields, low coordinate bits kept
  assign mrow[0] = m0[CW-1:0];
  assign mrow[1] = m1[CW-1:0];
  assign mrow[2] = m2[CW-1:0];
  assign mrow[3] = m3[CW-1:0];

  // Matrix store, entry index row*4+col
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < 16; e++) begin
        mat[e] <= '0;
      end
    end else if (in_xfer && (op == OP_LOAD)) begin
      for (int e = 0; e < 16; e++) begin
        if (row == 2'(e / 4)) begin
          mat[e] <= mrow[e % 4];
        end
      end
    end
  end

  // Planes: column 3 plus (even plane) or minus (odd plane) column k
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        n_next[2*k][i]   = NW'(mat[4*i+3]) + NW'(mat[4*i+k]);
        n_next[2*k+1][i] = NW'(mat[4*i+3]) - NW'(mat[4*i+k]);
      end
      d_next[2*k]   = NW'(mat[15]) + NW'(mat[12+k]);
      d_next[2*k+1] = NW'(mat[15]) - NW'(mat[12+k]);
    end
  end

  // Stage 1: capture planes and box at transfer
  always_ff @(posedge clk) begin
    if (en1) begin
      n1       <= n_next;
      d1       <= d_next;
      pos1[0]  <= pos_x[CW-1:0];
      pos1[1]  <= pos_y[CW-1:0];
      pos1[2]  <= pos_z[CW-1:0];
      size1[0] <= size_x[CW-1:0];
      size1[1] <= size_y[CW-1:0];
      size1[2] <= size_z[CW-1:0];
    end
  end

  // Valid bits travel with the tests; loads leave a bubble
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid && (op == OP_TEST);
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // Six plane evaluators
  for (genvar pl = 0; pl < 6; pl++) begin : g_plane
    fbc_plane #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_plane (
      .clk    (clk),
      .en     (pen),
      .n      (n1[pl]),
      .d      (d1[pl]),
      .pos    (pos1),
      .size   (size1),
      .culled (culled[pl])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en5) begin
      visible <= ~|culled;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fbc_plane.sv]
// One plane of the cull test: positive vertex, products, and sign of the distance.
`default_nettype none

module fbc_plane import fbc_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire fbc_en_t                       en,
  input  wire logic signed [COORD_WIDTH:0]   n [3],
  input  wire logic signed [COORD_WIDTH:0]   d,
  input  wire logic signed [COORD_WIDTH-1:0] pos [3],
  input  wire logic signed [COORD_WIDTH-1:0] size [3],
  output logic                               culled
);

  localparam int NW = COORD_WIDTH + 1;
  localparam int PW = 2 * NW;
  localparam int DW = NW + FRAC_BITS;
  localparam int AW = ((PW > DW) ? PW : DW) + 2;

  logic signed [NW-1:0] n2 [3];
  logic signed [NW-1:0] p2 [3];
  logic signed [NW-1:0] d2;
  logic signed [PW-1:0] prod3 [3];
  logic signed [DW-1:0] dsh3;
  logic signed [AW-1:0] sa4;
  logic signed [AW-1:0] sb4;
  logic signed [AW-1:0] plane_sum;

  // Stage 2: positive vertex, size added where the normal component is positive
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int i = 0; i < 3; i++) begin
        n2[i] <= n[i];
        if (!n[i][NW-1] && (n[i] != '0)) begin
          p2[i] <= NW'(pos[i]) + NW'(size[i]);
        end else begin
          p2[i] <= NW'(pos[i]);
        end
      end
      d2 <= d;
    end
  end

  // Stage 3: one product per axis, offset scaled to the product's fraction
  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int i = 0; i < 3; i++) begin
        prod3[i] <= PW'(n2[i]) * PW'(p2[i]);
      end
      dsh3 <= {d2, {FRAC_BITS{1'b0}}};
    end
  end

  // Stage 4: pairwise partial sums
  always_ff @(posedge clk) begin
    if (en.s4) begin
      sa4 <= AW'(prod3[0]) + AW'(prod3[1]);
      sb4 <= AW'(prod3[2]) + AW'(dsh3);
    end
  end

  // Final add; the box is outside when the distance is negative
  assign plane_sum = sa4 + sb4;
  assign culled    = plane_sum[AW-1];

endmodule

`default_nettype wire

[rtl/core/fbc_checker.sv]
// Port-level assertions for the frustum box cull block, bound to the top level.
`default_nettype none

`include "frustum_box_cull_assert.svh"

module fbc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic visible
);

  // Reset empties the output
  `FBC_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "out_valid high after reset")

  // A stalled result stays offered and unchanged
  `FBC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(visible), "stalled result changed")

  // Input backpressure only when the output is stalled with a result
  `FBC_ASSERT(a_ready_stall, !in_ready |-> out_valid && !out_ready, "in_ready low without output stall")

  // A result can appear only after in_valid was high at some earlier point
  `FBC_ASSERT(a_no_invent, $rose(out_valid) |-> $past(in_valid, 5) || $past(out_valid) || $past(in_valid, 1) || $past(in_valid, 2) || $past(in_valid, 3) || $past(in_valid, 4) || $past(in_valid, 6), "result without input")

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (.*);

`default_nettype wire

[dv/tb_frustum_box_cull.sv]
// Self-checking testbench for the frustum box cull block: directed table, random stream.
`default_nettype none

module tb_frustum_box_cull;
  import fbc_pkg::*;

  localparam int          N_RANDOM   = 1830;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          FRAC       = 16;
  localparam logic [31:0] ONE        = 32'h0001_0000;
  localparam logic [31:0] HALF       = 32'h0000_8000;
  localparam logic [31:0] MAX_POS    = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_NEG    = 32'h8000_0000;
  localparam logic [31:0] MINUS_ONE  = 32'hFFFF_FFFF;

  // Receiver stall patterns
  typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  // One row of stimulus; typed rows carry a hand-computed verdict
  typedef struct packed {
    logic        op;
    logic [1:0]  row;
    logic [31:0] m0, m1, m2, m3;
    logic [31:0] px, py, pz;
    logic [31:0] sx, sy, sz;
    logic        typed;
    logic        want;
  } stim_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               op;
  logic [1:0]         row;
  logic [FIELD_W-1:0] m0, m1, m2, m3;
  logic [FIELD_W-1:0] pos_x, pos_y, pos_z;
  logic [FIELD_W-1:0] size_x, size_y, size_z;
  logic               out_valid;
  logic               out_ready;
  logic               visible;

  // Local copy of the view-projection matrix, index row*4+col
  logic signed [31:0] view_matrix [16];
  bit                 expected_visible [$];
  stim_t              directed_rows [$];

  int       cycle_count;
  int       error_count;
  int       n_loads;
  int       n_tests;
  int       n_shown;
  int       n_culled;
  int       burst_left;
  int       rx_left;
  rx_mode_e rx_mode;

  frustum_box_cull u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .row       (row),
    .m0        (m0),
    .m1        (m1),
    .m2        (m2),
    .m3        (m3),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .size_x    (size_x),
    .size_y    (size_y),
    .size_z    (size_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .visible   (visible)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Six-plane positive-vertex test, exact in a 128-bit accumulator
  function automatic bit box_visible(input logic signed [31:0] px, py, pz, sx, sy, sz);
    logic signed [31:0]  corner [3];
    logic signed [31:0]  extent [3];
    longint              offset, normal, vertex;
    logic signed [127:0] acc, wn, wv;
    int                  k, s, i;
    bit                  all_in;
    all_in    = 1'b1;
    corner[0] = px; corner[1] = py; corner[2] = pz;
    extent[0] = sx; extent[1] = sy; extent[2] = sz;
    for (k = 0; k < 3; k++) begin
      for (s = 0; s < 2; s++) begin
        if (s == 0) offset = longint'(view_matrix[15]) + longint'(view_matrix[12 + k]);
        else        offset = longint'(view_matrix[15]) - longint'(view_matrix[12 + k]);
        acc = offset;
        acc = acc <<< FRAC;
        for (i = 0; i < 3; i++) begin
          if (s == 0) normal = longint'(view_matrix[i*4 + 3]) + longint'(view_matrix[i*4 + k]);
          else        normal = longint'(view_matrix[i*4 + 3]) - longint'(view_matrix[i*4 + k]);
          vertex = longint'(corner[i]);
          // positive vertex: take the far corner only where the normal points up
          if (normal > 0) vertex = vertex + longint'(extent[i]);
          wn  = normal;
          wv  = vertex;
          acc = acc + wn * wv;
        end
        if (acc < 0) all_in = 1'b0;
      end
    end
    return all_in;
  endfunction

  function automatic stim_t load_row(input logic [1:0] r,
                                     input logic [31:0] a, b, c, d);
    stim_t it;
    it     = '0;
    it.op  = OP_LOAD;
    it.row = r;
    it.m0  = a; it.m1 = b; it.m2 = c; it.m3 = d;
    return it;
  endfunction

  function automatic stim_t test_box(input logic [31:0] px, py, pz, sx, sy, sz,
                                     input logic typed, input logic want);
    stim_t it;
    it       = '0;
    it.op    = OP_TEST;
    it.px    = px; it.py = py; it.pz = pz;
    it.sx    = sx; it.sy = sy; it.sz = sz;
    it.typed = typed;
    it.want  = want;
    return it;
  endfunction

  function automatic logic [31:0] rand_small(input logic [31:0] span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Mostly small Q16.16 values, some full-range, some corner values
  function automatic logic [31:0] rand_field(input logic [31:0] span);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return rand_small(span);
    if (pick < 85) return $urandom;
    case ($urandom_range(0, 5))
      0:       return MAX_POS;
      1:       return MIN_NEG;
      2:       return '0;
      3:       return MINUS_ONE;
      4:       return ONE;
      default: return -ONE;
    endcase
  endfunction

  // Random item: loads lean towards frustum-like rows so tests split both ways
  function automatic stim_t random_item();
    stim_t       it;
    logic [31:0] v [4];
    int          c;
    it     = '0;
    it.row = 2'($urandom_range(0, 3));
    it.m0  = $urandom; it.m1 = $urandom; it.m2 = $urandom; it.m3 = $urandom;
    it.px  = $urandom; it.py = $urandom; it.pz = $urandom;
    it.sx  = $urandom; it.sy = $urandom; it.sz = $urandom;
    if ($urandom_range(0, 99) < 20) begin
      it.op = OP_LOAD;
      for (c = 0; c < 4; c++) begin
        if ($urandom_range(0, 99) < 60) begin
          if (c == it.row) v[c] = $urandom_range(HALF, 2 * ONE);
          else             v[c] = rand_small(ONE / 8);
        end else begin
          v[c] = rand_field(4 * ONE);
        end
      end
      it.m0 = v[0]; it.m1 = v[1]; it.m2 = v[2]; it.m3 = v[3];
    end else begin
      it.op = OP_TEST;
      it.px = rand_field(2 * ONE);
      it.py = rand_field(2 * ONE);
      it.pz = rand_field(2 * ONE);
      it.sx = rand_field(ONE);
      it.sy = rand_field(ONE);
      it.sz = rand_field(ONE);
    end
    return it;
  endfunction

  // Present one item and hold it until the transfer, then update the model
  task automatic transfer_item(input stim_t it);
    in_valid <= 1'b1;
    op       <= it.op;
    row      <= it.row;
    m0       <= it.m0; m1 <= it.m1; m2 <= it.m2; m3 <= it.m3;
    pos_x    <= it.px; pos_y <= it.py; pos_z <= it.pz;
    size_x   <= it.sx; size_y <= it.sy; size_z <= it.sz;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (it.op == OP_LOAD) begin
      view_matrix[int'(it.row)*4 + 0] = it.m0;
      view_matrix[int'(it.row)*4 + 1] = it.m1;
      view_matrix[int'(it.row)*4 + 2] = it.m2;
      view_matrix[int'(it.row)*4 + 3] = it.m3;
      n_loads++;
    end else begin
      if (it.typed) expected_visible.push_back(it.want);
      else expected_visible.push_back(box_visible(it.px, it.py, it.pz, it.sx, it.sy, it.sz));
      n_tests++;
    end
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender bursts with random gaps in between
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      idle($urandom_range(1, 10));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
    end
  endtask

  task automatic drain_results();
    idle(1);
    while (expected_visible.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern, picked anew when its random run length runs out
  always @(posedge clk) begin
    if (rx_left <= 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 60);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:     out_ready <= 1'b1;
      RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready <= (cycle_count[1:0] == 2'd0);
      default:     out_ready <= 1'b1;
    endcase
  end

  // Result checker
  always @(posedge clk) begin : result_check
    bit want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_visible.size() == 0) begin
        $display("%0t: unexpected result transfer, visible=%b", $time, visible);
        error_count++;
      end else begin
        want = expected_visible.pop_front();
        if (visible !== want) begin
          $display("%0t: visible mismatch, expected %b actual %b", $time, want, visible);
          error_count++;
        end
        if (want) n_shown++;
        else      n_culled++;
      end
    end
  end

  // Cycle counter with run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin : main_seq
    int idx;
    cycle_count = 0;
    error_count = 0;
    n_loads     = 0;
    n_tests     = 0;
    n_shown     = 0;
    n_culled    = 0;
    rx_left     = 0;
    rx_mode     = RX_FREE;
    for (idx = 0; idx < 16; idx++) view_matrix[idx] = '0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    out_ready <= 1'b0;
    op        <= OP_LOAD;
    row       <= '0;
    m0 <= '0; m1 <= '0; m2 <= '0; m3 <= '0;
    pos_x <= '0; pos_y <= '0; pos_z <= '0;
    size_x <= '0; size_y <= '0; size_z <= '0;

    // Directed table: reset matrix, degenerate planes, unit frustum, extremes
    directed_rows.push_back(test_box('0, '0, '0, '0, '0, '0, 1'b1, 1'b1));
    directed_rows.push_back(test_box(MAX_POS, MIN_NEG, MAX_POS, MIN_NEG, MAX_POS, MINUS_ONE,
                                     1'b1, 1'b1));
    directed_rows.push_back(load_row(2'd3, '0, '0, '0, MINUS_ONE));
    directed_rows.push_back(test_box('0, '0, '0, '0, '0, '0, 1'b1, 1'b0));
    directed_rows.push_back(load_row(2'd3, '0, '0, '0, ONE));
    directed_rows.push_back(test_box(MIN_NEG, MAX_POS, MIN_NEG, MAX_POS, MIN_NEG, MAX_POS,
                                     1'b1, 1'b1));
    directed_rows.push_back(load_row(2'd0, ONE, '0, '0, '0));
    directed_rows.push_back(load_row(2'd1, '0, ONE, '0, '0));
    directed_rows.push_back(load_row(2'd2, '0, '0, ONE, '0));
    directed_rows.push_back(test_box(-HALF, -HALF, -HALF, ONE, ONE, ONE, 1'b0, 1'b0));
    directed_rows.push_back(test_box(HALF, HALF, HALF, ONE, ONE, ONE, 1'b0, 1'b0));
    directed_rows.push_back(test_box(2 * ONE, '0, '0, HALF, HALF, HALF, 1'b0, 1'b0));
    directed_rows.push_back(test_box('0, -3 * ONE, '0, HALF, ONE, HALF, 1'b0, 1'b0));
    directed_rows.push_back(test_box('0, '0, '0, -4 * ONE, HALF, HALF, 1'b0, 1'b0));
    directed_rows.push_back(test_box(ONE, '0, '0, '0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(load_row(2'd3, MIN_NEG, MAX_POS, MIN_NEG, MAX_POS));
    directed_rows.push_back(load_row(2'd0, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG));
    directed_rows.push_back(load_row(2'd1, MAX_POS, MAX_POS, MAX_POS, MAX_POS));
    directed_rows.push_back(load_row(2'd2, MAX_POS, MIN_NEG, '0, MINUS_ONE));
    directed_rows.push_back(test_box(MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS,
                                     1'b0, 1'b0));
    directed_rows.push_back(test_box(MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG,
                                     1'b0, 1'b0));
    directed_rows.push_back(test_box(MAX_POS, MIN_NEG, '0, MINUS_ONE, MAX_POS, MIN_NEG,
                                     1'b0, 1'b0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 16);

    foreach (directed_rows[idx]) begin
      transfer_item(directed_rows[idx]);
      pace();
    end
    drain_results();

    // Random stream, with a full drain halfway through
    for (idx = 0; idx < N_RANDOM; idx++) begin
      transfer_item(random_item());
      pace();
      if (idx == N_RANDOM / 2) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d matrix row loads and %0d box tests in %0d cycles",
             n_loads, n_tests, cycle_count);
    $display("Results seen: %0d visible, %0d culled, %0d errors", n_shown, n_culled, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
